/* design/mu_law_bit_crusher_unit_defines.svh */
// Assertion macros used by the mu-law bit crusher checker
`ifndef MU_LAW_BIT_CRUSHER_UNIT_DEFINES_SVH
`define MU_LAW_BIT_CRUSHER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MLBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlbc: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MLBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlbc: next-cycle check failed");

`endif

/* design/mlbc_pkg.sv */
// Shared types, register codes and constant tables of the mu-law bit crusher
`timescale 1ns / 1ps

package mlbc_pkg;

    localparam int MAX_SAMPLE_BITS = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int LOG_STEPS       = 32;
    localparam int EXP_STEPS       = 32;
    localparam int LEVEL_BITS      = 16;
    localparam int NORM_SPAN       = 9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MU         = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CRUSH_BITS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BYPASS     = 2'd2;

    localparam logic [15:0] MU_RESET         = 16'd65280;
    localparam logic [15:0] MU_MIN           = 16'd256;
    localparam logic [3:0]  CRUSH_BITS_RESET = 4'd7;

    typedef struct packed {
        logic [31:0] raw;
        logic        neg;
        logic [3:0]  bits;
        logic [15:0] m;
        logic [47:0] u;
        logic [47:0] v;
        logic [31:0] zu;
        logic [31:0] zv;
        logic [35:0] lu;
        logic [35:0] lv;
        logic [52:0] rem;
        logic [35:0] dvs;
        logic [33:0] quo;
        logic [31:0] ef;
        logic [3:0]  ei;
        logic [32:0] acc;
    } item_t;

    // Q31 root 2^(2^-idx), each step a truncating integer square root
    function automatic logic [63:0] exp_root(input int idx);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        int i;
        int j;
        r = 64'h0000_0001_0000_0000;
        for (i = 1; i <= EXP_STEPS; i++)
        begin
            if (i <= idx)
            begin
                v   = r << 31;
                res = '0;
                bt  = 64'h4000_0000_0000_0000;
                for (j = 0; j < 32; j++)
                begin
                    if (v >= res + bt)
                    begin
                        v   = v - (res + bt);
                        res = (res >> 1) + bt;
                    end
                    else
                    begin
                        res = res >> 1;
                    end
                    bt = bt >> 2;
                end
                r = res;
            end
        end
        return r;
    endfunction

endpackage

/* design/mlbc_log_cell.sv */
// One squaring step of the log2 mantissa chain, for both numerator and scale
`timescale 1ns / 1ps

module mlbc_log_cell
    import mlbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [63:0] sq_u;
    logic [63:0] sq_v;
    logic [32:0] t_u;
    logic [32:0] t_v;

    always_comb
    begin
        item_next = in_item;
        sq_u      = in_item.zu * in_item.zu;
        sq_v      = in_item.zv * in_item.zv;
        t_u       = sq_u[63:31];
        t_v       = sq_v[63:31];
        item_next.zu = t_u[32] ? t_u[32:1] : t_u[31:0];
        item_next.zv = t_v[32] ? t_v[32:1] : t_v[31:0];
        item_next.lu[31:0] = {in_item.lu[30:0], t_u[32]};
        item_next.lv[31:0] = {in_item.lv[30:0], t_v[32]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/mlbc_div_cell.sv */
// One restoring quotient bit of a long division
`timescale 1ns / 1ps

module mlbc_div_cell
    import mlbc_pkg::*;
#(
    parameter int QBIT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [69:0] dvs_shift;
    logic [69:0] rem_wide;

    always_comb
    begin
        item_next = in_item;
        dvs_shift = {34'b0, in_item.dvs} << QBIT;
        rem_wide  = {17'b0, in_item.rem};
        if (rem_wide >= dvs_shift)
        begin
            item_next.rem       = in_item.rem - dvs_shift[52:0];
            item_next.quo[QBIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/mlbc_exp_cell.sv */
// One root factor of the 2^frac product chain
`timescale 1ns / 1ps

module mlbc_exp_cell
    import mlbc_pkg::*;
#(
    parameter int STEP = 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    localparam logic [31:0] ROOT = 32'(exp_root(STEP));
    localparam int          TAP  = EXP_STEPS - STEP;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [64:0] prod;

    always_comb
    begin
        item_next = in_item;
        prod      = in_item.acc * ROOT;
        if (in_item.ef[TAP])
        begin
            item_next.acc = prod[63:31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/mu_law_bit_crusher_unit.sv */
// Top level of the mu-law bit crusher: config registers and the cell pipeline
//
//  channel     | signals                                  | direction
//  ------------+------------------------------------------+----------
//  config      | cfg_we, cfg_index, cfg_data              | in
//  audio       | audio_sample, audio_valid, audio_ready   | in
//  processed   | processed_sample, processed_valid/ready  | out
//
//  One beat per cycle is accepted while the output is not stalled; every cell stage advances together.
//  The pipeline holds 32 log cells, 16 level divide cells, 32 exp cells,
//  SAMPLE_BITS + 2 output divide cells and seven top stages.
//  Reset clears all stage valid bits and loads the register reset values.
//  A stalled output register holds the whole pipeline and drops audio_ready.
`timescale 1ns / 1ps

module mu_law_bit_crusher_unit
    import mlbc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] audio_sample,
    input  logic                          audio_valid,
    output logic                          audio_ready,
    output logic signed [SAMPLE_BITS-1:0] processed_sample,
    output logic                          processed_valid,
    input  logic                          processed_ready
);

    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int SCALE_BITS = FRAC_BITS + 8;
    localparam int U_BITS     = SAMPLE_BITS + 16;
    localparam int QUO2_BITS  = SAMPLE_BITS + 2;
    localparam int DEN_SHIFT  = 31 - FRAC_BITS;

    logic [15:0] mu_reg;
    logic [3:0]  crush_bits_reg;
    logic        bypass_reg;
    logic        adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg         <= MU_RESET;
            crush_bits_reg <= CRUSH_BITS_RESET;
            bypass_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MU:         mu_reg         <= cfg_data;
                REG_CRUSH_BITS: crush_bits_reg <= cfg_data[3:0];
                REG_BYPASS:     bypass_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // entry: magnitude and the two QS log arguments
    logic [SAMPLE_BITS-1:0] sample_raw;
    logic [SAMPLE_BITS-1:0] sample_mag;
    logic [15:0]            m_eff;
    logic [U_BITS-1:0]      u_prod;
    logic [U_BITS-1:0]      u_calc;
    logic [U_BITS-1:0]      v_calc;
    item_t                  s0_next;
    item_t                  s0_item_reg;
    logic                   s0_valid_reg;

    always_comb
    begin
        sample_raw = audio_sample;
        sample_mag = sample_raw[SAMPLE_BITS-1] ? (~sample_raw + 1'b1) : sample_raw;
        m_eff      = (mu_reg < MU_MIN) ? MU_MIN : mu_reg;
        u_prod     = m_eff * sample_mag;
        u_calc     = u_prod + (U_BITS'(1) << SCALE_BITS);
        v_calc     = (U_BITS'(1) << SCALE_BITS) + (U_BITS'(m_eff) << FRAC_BITS);
        s0_next      = '0;
        s0_next.raw  = MAX_SAMPLE_BITS'(sample_raw);
        s0_next.neg  = sample_raw[SAMPLE_BITS-1];
        s0_next.bits = crush_bits_reg;
        s0_next.m    = m_eff;
        s0_next.u    = 48'(u_calc);
        s0_next.v    = 48'(v_calc);
    end

    // normalize: top bit search over the nine possible positions
    function automatic logic [35:0] norm_q31(input logic [U_BITS-1:0] x);
        logic [3:0]         n;
        logic [U_BITS+30:0] ext;
        logic [U_BITS+30:0] sh;
        int j;
        n = '0;
        for (j = 0; j < NORM_SPAN; j++)
        begin
            if (x[SCALE_BITS+j])
            begin
                n = 4'(j);
            end
        end
        ext = {x, 31'b0};
        sh  = ext >> (SCALE_BITS + int'(n));
        return {n, sh[31:0]};
    endfunction

    logic [35:0] nz_u;
    logic [35:0] nz_v;
    item_t       s1_next;
    item_t       s1_item_reg;
    logic        s1_valid_reg;

    always_comb
    begin
        nz_u       = norm_q31(s0_item_reg.u[U_BITS-1:0]);
        nz_v       = norm_q31(s0_item_reg.v[U_BITS-1:0]);
        s1_next    = s0_item_reg;
        s1_next.zu = nz_u[31:0];
        s1_next.zv = nz_v[31:0];
        s1_next.lu = {nz_u[35:32], 32'b0};
        s1_next.lv = {nz_v[35:32], 32'b0};
    end

    // log chain
    logic  log_valid [LOG_STEPS+1];
    item_t log_item  [LOG_STEPS+1];

    assign log_valid[0] = s1_valid_reg;
    assign log_item[0]  = s1_item_reg;

    for (genvar g = 0; g < LOG_STEPS; g++)
    begin : g_log
        mlbc_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (log_valid[g]),
            .in_item   (log_item[g]),
            .out_valid (log_valid[g+1]),
            .out_item  (log_item[g+1])
        );
    end

    // level divide setup: floor for positive, ceil for negative
    logic [51:0] num;
    item_t       d1_next;
    item_t       d1_item_reg;
    logic        d1_valid_reg;

    always_comb
    begin
        num         = {16'b0, log_item[LOG_STEPS].lu} << log_item[LOG_STEPS].bits;
        d1_next     = log_item[LOG_STEPS];
        d1_next.rem = 53'(num);
        if (log_item[LOG_STEPS].neg)
        begin
            d1_next.rem = 53'(num) + 53'(log_item[LOG_STEPS].lv) - 53'd1;
        end
        d1_next.dvs = log_item[LOG_STEPS].lv;
        d1_next.quo = '0;
    end

    logic  div1_valid [LEVEL_BITS+1];
    item_t div1_item  [LEVEL_BITS+1];

    assign div1_valid[0] = d1_valid_reg;
    assign div1_item[0]  = d1_item_reg;

    for (genvar g = 0; g < LEVEL_BITS; g++)
    begin : g_div1
        mlbc_div_cell #(.QBIT(LEVEL_BITS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (div1_valid[g]),
            .in_item   (div1_item[g]),
            .out_valid (div1_valid[g+1]),
            .out_item  (div1_item[g+1])
        );
    end

    // exponent: level times log scale, then drop the crush bits
    logic [51:0] lev_prod;
    item_t       pr_next;
    item_t       pr_item_reg;
    logic        pr_valid_reg;
    logic [52:0] e_full;
    item_t       ex_next;
    item_t       ex_item_reg;
    logic        ex_valid_reg;

    always_comb
    begin
        lev_prod    = div1_item[LEVEL_BITS].quo[LEVEL_BITS-1:0] * div1_item[LEVEL_BITS].lv;
        pr_next     = div1_item[LEVEL_BITS];
        pr_next.rem = 53'(lev_prod);
        e_full      = pr_item_reg.rem >> pr_item_reg.bits;
        ex_next     = pr_item_reg;
        ex_next.ef  = e_full[31:0];
        ex_next.ei  = e_full[35:32];
        ex_next.acc = 33'h0_8000_0000;
    end

    logic  exp_valid [EXP_STEPS+1];
    item_t exp_item  [EXP_STEPS+1];

    assign exp_valid[0] = ex_valid_reg;
    assign exp_item[0]  = ex_item_reg;

    for (genvar g = 0; g < EXP_STEPS; g++)
    begin : g_exp
        mlbc_exp_cell #(.STEP(g + 1)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (exp_valid[g]),
            .in_item   (exp_item[g]),
            .out_valid (exp_valid[g+1]),
            .out_item  (exp_item[g+1])
        );
    end

    // expansion divide setup: (P - 1.0) << 8 over mu
    logic [40:0] p_val;
    logic [40:0] d_val;
    item_t       d2_next;
    item_t       d2_item_reg;
    logic        d2_valid_reg;

    always_comb
    begin
        p_val       = {8'b0, exp_item[EXP_STEPS].acc} << exp_item[EXP_STEPS].ei;
        d_val       = p_val - 41'h0_0080_0000_00;
        d2_next     = exp_item[EXP_STEPS];
        d2_next.rem = 53'({d_val, 8'b0});
        d2_next.dvs = {20'b0, exp_item[EXP_STEPS].m} << DEN_SHIFT;
        d2_next.quo = '0;
    end

    logic  div2_valid [QUO2_BITS+1];
    item_t div2_item  [QUO2_BITS+1];

    assign div2_valid[0] = d2_valid_reg;
    assign div2_item[0]  = d2_item_reg;

    for (genvar g = 0; g < QUO2_BITS; g++)
    begin : g_div2
        mlbc_div_cell #(.QBIT(QUO2_BITS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (div2_valid[g]),
            .in_item   (div2_item[g]),
            .out_valid (div2_valid[g+1]),
            .out_item  (div2_item[g+1])
        );
    end

    // saturate, sign and bypass select
    logic [33:0]            mag;
    logic [33:0]            mag_sat;
    logic [33:0]            mag_neg;
    logic [SAMPLE_BITS-1:0] out_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_valid_reg;

    always_comb
    begin
        mag     = div2_item[QUO2_BITS].quo;
        mag_sat = mag;
        mag_neg = '0;
        if (div2_item[QUO2_BITS].neg)
        begin
            if (mag > (34'(1) << FRAC_BITS))
            begin
                mag_sat = 34'(1) << FRAC_BITS;
            end
            mag_neg  = ~mag_sat + 34'd1;
            out_next = mag_neg[SAMPLE_BITS-1:0];
        end
        else
        begin
            if (mag > ((34'(1) << FRAC_BITS) - 34'd1))
            begin
                mag_sat = (34'(1) << FRAC_BITS) - 34'd1;
            end
            out_next = mag_sat[SAMPLE_BITS-1:0];
        end
        if (bypass_reg)
        begin
            out_next = div2_item[QUO2_BITS].raw[SAMPLE_BITS-1:0];
        end
    end

    assign adv = !out_valid_reg || processed_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            d1_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            ex_valid_reg  <= 1'b0;
            d2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= audio_valid;
            s1_valid_reg  <= s0_valid_reg;
            d1_valid_reg  <= log_valid[LOG_STEPS];
            pr_valid_reg  <= div1_valid[LEVEL_BITS];
            ex_valid_reg  <= pr_valid_reg;
            d2_valid_reg  <= exp_valid[EXP_STEPS];
            out_valid_reg <= div2_valid[QUO2_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg    <= s0_next;
            s1_item_reg    <= s1_next;
            d1_item_reg    <= d1_next;
            pr_item_reg    <= pr_next;
            ex_item_reg    <= ex_next;
            d2_item_reg    <= d2_next;
            out_sample_reg <= out_next;
        end
    end

    assign audio_ready      = adv;
    assign processed_valid  = out_valid_reg;
    assign processed_sample = out_sample_reg;

endmodule

/* design/mlbc_checker.sv */
// Port-level checks of the mu-law bit crusher handshakes, bound to the top level
`timescale 1ns / 1ps
`include "mu_law_bit_crusher_unit_defines.svh"

module mlbc_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          audio_ready,
    input logic signed [SAMPLE_BITS-1:0] processed_sample,
    input logic                          processed_valid,
    input logic                          processed_ready
);

    `MLBC_ASSERT_NEXT(a_out_hold, processed_valid && !processed_ready, processed_valid && $stable(processed_sample))
    `MLBC_ASSERT_IMP(a_out_drop, $past(processed_valid) && !processed_valid, $past(processed_ready))
    `MLBC_ASSERT_IMP(a_stall_blocks_in, processed_valid && !processed_ready, !audio_ready)
    `MLBC_ASSERT_IMP(a_ready_only_on_stall, !audio_ready, processed_valid && !processed_ready)

endmodule

bind mu_law_bit_crusher_unit mlbc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mlbc_checker (.*);

/* tb/sv/tb_mu_law_bit_crusher_unit.sv */
// Self-checking testbench for the mu-law bit crusher unit
`timescale 1ns / 1ps

module tb_mu_law_bit_crusher_unit;
    import mlbc_pkg::*;

    localparam int SB  = 24;
    localparam int FB  = SB - 1;
    localparam int SCB = FB + 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic signed [SB-1:0]  audio_sample;
    logic                  audio_valid;
    logic                  audio_ready;
    logic signed [SB-1:0]  processed_sample;
    logic                  processed_valid;
    logic                  processed_ready;

    logic [SB-1:0] pending_samples[$];
    logic [SB-1:0] expected_samples[$];
    logic [63:0]   exp_roots[1:32];
    logic [15:0]   cur_mu;
    logic [3:0]    cur_bits;
    logic          cur_bypass;
    int            send_idle;
    int            recv_idle;
    int            error_count;

    mu_law_bit_crusher_unit #(.SAMPLE_BITS(SB)) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .audio_sample     (audio_sample),
        .audio_valid      (audio_valid),
        .audio_ready      (audio_ready),
        .processed_sample (processed_sample),
        .processed_valid  (processed_valid),
        .processed_ready  (processed_ready)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = val;
        res = '0;
        bt  = 64'h4000_0000_0000_0000;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] log2_fixed(input logic [63:0] u);
        int          p;
        logic [63:0] n;
        logic [63:0] z;
        logic [63:0] frac;
        p = 0;
        for (int i = 1; i < 64; i++)
            if (u[i])
                p = i;
        n = (p >= SCB) ? 64'(p - SCB) : 64'd0;
        z = (p >= 31) ? (u >> (p - 31)) : (u << (31 - p));
        frac = '0;
        for (int i = 0; i < 32; i++)
        begin
            z = (z * z) >> 31;
            frac = frac << 1;
            if (z >= 64'h1_0000_0000)
            begin
                z = z >> 1;
                frac[0] = 1'b1;
            end
        end
        return (n << 32) | frac;
    endfunction

    function automatic logic [SB-1:0] crushed_sample(input logic [SB-1:0] raw);
        logic        neg;
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] lu;
        logic [63:0] lv;
        logic [63:0] num;
        logic [63:0] k;
        logic [63:0] e;
        logic [63:0] acc;
        logic [63:0] p;
        logic [63:0] mag;
        logic [SB-1:0] neg_mag;
        if (cur_bypass)
            return raw;
        neg = raw[SB-1];
        a   = neg ? 64'(SB'(~raw + 1'b1)) : 64'(raw);
        if (neg && a == 0)
            a = 64'd1 << FB;
        m  = (cur_mu < MU_MIN) ? 64'(MU_MIN) : 64'(cur_mu);
        u  = (64'd1 << SCB) + m * a;
        v  = (64'd1 << SCB) + (m << FB);
        lu = log2_fixed(u);
        lv = log2_fixed(v);
        num = lu << cur_bits;
        k   = neg ? (num + lv - 1) / lv : num / lv;
        e   = (k * lv) >> cur_bits;
        acc = 64'd1 << 31;
        for (int i = 1; i <= 32; i++)
            if (e[32 - i])
                acc = (acc * exp_roots[i]) >> 31;
        p   = acc << e[63:32];
        mag = ((p - (64'd1 << 31)) << 8) / (m << (31 - FB));
        if (neg)
        begin
            if (mag > (64'd1 << FB))
                mag = 64'd1 << FB;
            neg_mag = SB'(~mag + 1);
            return neg_mag;
        end
        if (mag > (64'd1 << FB) - 1)
            mag = (64'd1 << FB) - 1;
        return SB'(mag);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MU:         cur_mu     = data;
            REG_CRUSH_BITS: cur_bits   = data[3:0];
            REG_BYPASS:     cur_bypass = data[0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_samples.size() != 0 || audio_valid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    function automatic logic [SB-1:0] random_sample();
        case ($urandom_range(5))
            0:       return SB'($urandom_range(255));
            1:       return SB'(-$signed({1'b0, 8'($urandom_range(255))}));
            2:       return SB'($urandom_range(65535)) ^ {SB{$urandom_range(1) == 1}};
            3:       return $urandom_range(1) ? {1'b0, {FB{1'b1}}} : {1'b1, {FB{1'b0}}};
            default: return SB'($urandom());
        endcase
    endfunction

    // drive audio beats from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_valid  <= 1'b0;
            audio_sample <= '0;
        end
        else
        begin
            if (audio_valid && audio_ready)
                expected_samples.push_back(crushed_sample(audio_sample));
            if (!audio_valid || audio_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    audio_valid  <= 1'b1;
                    audio_sample <= pending_samples.pop_front();
                end
                else
                begin
                    audio_valid <= 1'b0;
                end
            end
        end
    end

    // check processed beats against the expected queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            processed_ready <= 1'b0;
        end
        else
        begin
            if (processed_valid && processed_ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected beat %h", processed_sample));
                else if (processed_sample !== expected_samples[0])
                    report_mismatch($sformatf("processed_sample %h, expected %h",
                                              processed_sample, expected_samples[0]));
                if (expected_samples.size() != 0)
                    void'(expected_samples.pop_front());
            end
            processed_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        logic [15:0] mu_pick[7];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        send_idle = 33;
        recv_idle = 68;
        cur_mu = MU_RESET;
        cur_bits = CRUSH_BITS_RESET;
        cur_bypass = 1'b0;
        exp_roots[1] = int_sqrt(64'h1_0000_0000 << 31);
        for (int i = 2; i <= 32; i++)
            exp_roots[i] = int_sqrt(exp_roots[i - 1] << 31);
        mu_pick = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd65280, 16'd65535, 16'd4096};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        pending_samples = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800000,
                            24'h400000, 24'hC00000, 24'h555555, 24'hAAAAAA, 24'h000100,
                            24'hFFFF00, 24'h7FFFFE, 24'h800001};
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_BYPASS, 16'hFFFF);
        pending_samples = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h555555, 24'hAAAAAA,
                            24'h123456};
        drain();
        write_reg(REG_BYPASS, 16'h0000);
        write_reg(REG_MU, 16'd0);
        write_reg(REG_CRUSH_BITS, 16'h0000);
        pending_samples = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h000000,
                            24'h200000};
        drain();

        for (int ph = 0; ph < 16; ph++)
        begin
            send_idle = (ph < 6) ? 33 : (ph < 11) ? 68 : 0;
            recv_idle = (ph < 6) ? 68 : (ph < 11) ? 33 : 0;
            write_reg(REG_MU, (ph % 4 == 3) ? 16'($urandom()) : mu_pick[ph % 7]);
            write_reg(REG_CRUSH_BITS, {12'($urandom()), 4'(ph)});
            write_reg(REG_BYPASS, {15'($urandom()), ph == 5 || ph == 12});
            for (int i = 0; i < 34; i++)
                pending_samples.push_back(random_sample());
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/mlbc_pkg.sv
design/mlbc_log_cell.sv
design/mlbc_div_cell.sv
design/mlbc_exp_cell.sv
design/mu_law_bit_crusher_unit.sv
design/mlbc_checker.sv
tb/sv/tb_mu_law_bit_crusher_unit.sv
